FILE: hdl/mee_pkg.sv
// mee_pkg: types and constants for the cop0 exception-entry block
// no dependencies; used by mee_logic and mips_exception_entry_top
`timescale 1ns / 1ps

package mee_pkg;

  // event kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_TLB   = 2'd1,
    OP_BREAK = 2'd2,
    OP_TRAP  = 2'd3
  } op_e;

  // exception codes, already placed at cause bits 6..2
  localparam logic [31:0] CODE_INT  = 32'd0;
  localparam logic [31:0] CODE_TLBL = 32'd8;
  localparam logic [31:0] CODE_TLBS = 32'd12;
  localparam logic [31:0] CODE_BP   = 32'd36;
  localparam logic [31:0] CODE_TR   = 32'd52;

  localparam logic [31:0] STATUS_EXL  = 32'h0000_0002;
  localparam int unsigned STATUS_BEV_BIT = 22;
  localparam logic [2:0]  STATUS_IE_ONLY = 3'b001;
  localparam logic [31:0] CAUSE_BD    = 32'h8000_0000;
  localparam logic [31:0] CAUSE_TIMER = 32'h0000_8000;
  localparam logic [31:0] IP_MASK     = 32'h0000_FF00;

  // exception vectors
  localparam logic [31:0] VEC_INT_BEV  = 32'hBFC0_0380;
  localparam logic [31:0] VEC_INT      = 32'h8000_0180;
  localparam logic [31:0] VEC_TLB_BEV  = 32'hBFC0_01FC;
  localparam logic [31:0] VEC_TLB      = 32'h7FFF_FFFC;
  localparam logic [31:0] VEC_GEN_BEV  = 32'hBFC0_037C;
  localparam logic [31:0] VEC_GEN      = 32'h8000_017C;

  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 232;

  typedef struct packed {
    op_e         operation;
    logic [31:0] address;
    logic        is_store;
    logic [31:0] current_pc;
    logic        in_delay_slot;
    logic [31:0] current_status;
    logic [31:0] current_cause;
    logic [31:0] count_value;
    logic [31:0] compare_value;
    logic        interrupt_pending;
  } item_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] new_epc;
    logic [31:0] new_cause;
    logic [31:0] new_status;
    logic        fault_regs_valid;
    logic [31:0] bad_vaddr;
    logic [31:0] context_word;
    logic [31:0] entry_hi_word;
    logic [31:0] next_pc;
  } result_t;

endpackage

FILE: hdl/mips_exception_entry_top.sv
// mips_exception_entry_top: stream wrapper with input and result registers
// depends on mee_pkg and mee_logic
// a request is registered in the input stage, then its result in the result register on the master side
// throughput: one request per cycle while the master side accepts results, set by the single-pass decode logic
// a request is taken while a result waits, as long as the input stage is free
// reset (rst_ni low, asynchronous) empties both stages; payload is not cleared
`timescale 1ns / 1ps

module mips_exception_entry_top
  import mee_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // address, is_store, current_pc, in_delay_slot, current_status,
  // current_cause, count_value, compare_value, interrupt_pending, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // taken, new_epc, new_cause, new_status, fault_regs_valid, bad_vaddr,
  // context_word, entry_hi_word, next_pc, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  item_t   item_d, item_q;
  logic    in_valid_q;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    advance;

  // unpack the request
  always_comb begin
    item_d.operation         = op_e'(s_axis_tuser);
    item_d.address           = s_axis_tdata[31:0];
    item_d.is_store          = s_axis_tdata[32];
    item_d.current_pc        = s_axis_tdata[64:33];
    item_d.in_delay_slot     = s_axis_tdata[65];
    item_d.current_status    = s_axis_tdata[97:66];
    item_d.current_cause     = s_axis_tdata[129:98];
    item_d.count_value       = s_axis_tdata[161:130];
    item_d.compare_value     = s_axis_tdata[193:162];
    item_d.interrupt_pending = s_axis_tdata[194];
  end

  // handshake: input stage moves on when the result register is empty or its result is being taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  mee_logic u_logic (
    .item_i   (item_q),
    .result_o (result_d)
  );

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  // pack the result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0,
                          result_q.next_pc,
                          result_q.entry_hi_word,
                          result_q.context_word,
                          result_q.bad_vaddr,
                          result_q.fault_regs_valid,
                          result_q.new_status,
                          result_q.new_cause,
                          result_q.new_epc,
                          result_q.taken};

endmodule

FILE: hdl/mee_logic.sv
// mee_logic: exception decision, cause/status update, tlb fault words, vector
// depends on mee_pkg
`timescale 1ns / 1ps

module mee_logic
  import mee_pkg::*;
(
  input  item_t   item_i,
  output result_t result_o
);

  logic [31:0] poll_cause;
  logic        poll_taken;
  logic        bev;
  logic        taken;
  logic [31:0] code;
  logic [31:0] vector;
  logic        is_tlb;

  assign bev    = item_i.current_status[STATUS_BEV_BIT];
  assign is_tlb = (item_i.operation == OP_TLB);

  // timer match and pending update of cause for a poll
  always_comb begin
    poll_cause = item_i.current_cause;
    if (item_i.count_value == item_i.compare_value) begin
      poll_cause = poll_cause | CAUSE_TIMER;
    end
    if (!item_i.interrupt_pending) begin
      poll_cause = poll_cause & ~IP_MASK;
    end
  end

  assign poll_taken = (item_i.current_status[2:0] == STATUS_IE_ONLY) &&
                      ((item_i.current_status[15:8] & poll_cause[15:8]) != 8'd0);

  // exception kind decode
  always_comb begin
    unique case (item_i.operation)
      OP_POLL: begin
        taken  = poll_taken;
        code   = CODE_INT;
        vector = bev ? VEC_INT_BEV : VEC_INT;
      end
      OP_TLB: begin
        taken  = 1'b1;
        code   = item_i.is_store ? CODE_TLBS : CODE_TLBL;
        vector = bev ? VEC_TLB_BEV : VEC_TLB;
      end
      OP_BREAK: begin
        taken  = 1'b1;
        code   = CODE_BP;
        vector = bev ? VEC_GEN_BEV : VEC_GEN;
      end
      default: begin
        taken  = 1'b1;
        code   = CODE_TR;
        vector = bev ? VEC_GEN_BEV : VEC_GEN;
      end
    endcase
  end

  // result assembly
  always_comb begin
    result_o.taken            = taken;
    result_o.new_epc          = 32'd0;
    result_o.new_cause        = (item_i.operation == OP_POLL) ? poll_cause
                                                              : item_i.current_cause;
    result_o.new_status       = item_i.current_status;
    result_o.next_pc          = 32'd0;
    result_o.fault_regs_valid = is_tlb;
    result_o.bad_vaddr        = is_tlb ? item_i.address : 32'd0;
    result_o.context_word     = is_tlb ? {9'd0, item_i.address[31:13], 4'd0} : 32'd0;
    result_o.entry_hi_word    = is_tlb ? {item_i.address[31:13], 13'd0} : 32'd0;
    if (taken) begin
      result_o.new_epc    = item_i.in_delay_slot ? (item_i.current_pc - 32'd4)
                                                 : item_i.current_pc;
      result_o.new_cause  = result_o.new_cause | code |
                            (item_i.in_delay_slot ? CAUSE_BD : 32'd0);
      result_o.new_status = item_i.current_status | STATUS_EXL;
      result_o.next_pc    = vector;
    end
  end

endmodule

FILE: sim/mips_exception_entry_top_test.sv
// mips_exception_entry_top_test: stream-level testbench for the cop0 exception-entry block
// predicts each result from the accepted request and checks it field by field
// depends on mee_pkg and mips_exception_entry_top
`timescale 1ns / 1ps

module mips_exception_entry_top_test;
  import mee_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // idling controls, changed by the main sequence between phases
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_len;
  logic        snk_hold;
  event        start_hold;

  // exception-entry predictor and store of expected results
  class entry_scoreboard;
    result_t     expected_q[$];
    int unsigned mismatches;
    int unsigned op_seen[4];
    int unsigned taken_seen;
    int unsigned fault_seen;

    function new();
      mismatches = 0;
      taken_seen = 0;
      fault_seen = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // work out Cause, Status, EPC, fault words and vector for one request
    function result_t predict_entry(item_t it);
      result_t     r;
      logic [31:0] cause;
      logic [31:0] code;
      logic [31:0] vpn2;
      logic        bev;
      r     = '0;
      cause = it.current_cause;
      code  = CODE_INT;
      bev   = it.current_status[STATUS_BEV_BIT];
      r.new_status = it.current_status;
      case (it.operation)
        OP_POLL: begin
          if (it.count_value == it.compare_value) cause |= CAUSE_TIMER;
          if (!it.interrupt_pending) cause &= ~IP_MASK;
          if (it.current_status[2:0] == STATUS_IE_ONLY &&
              (it.current_status & cause & IP_MASK) != 32'd0) begin
            r.taken   = 1'b1;
            r.next_pc = bev ? VEC_INT_BEV : VEC_INT;
          end
        end
        OP_TLB: begin
          vpn2               = it.address >> 13;
          r.taken            = 1'b1;
          r.fault_regs_valid = 1'b1;
          r.bad_vaddr        = it.address;
          r.context_word     = vpn2 << 4;
          r.entry_hi_word    = vpn2 << 13;
          code               = it.is_store ? CODE_TLBS : CODE_TLBL;
          r.next_pc          = bev ? VEC_TLB_BEV : VEC_TLB;
        end
        default: begin
          r.taken   = 1'b1;
          code      = (it.operation == OP_BREAK) ? CODE_BP : CODE_TR;
          r.next_pc = bev ? VEC_GEN_BEV : VEC_GEN;
        end
      endcase
      if (r.taken) begin
        r.new_epc    = it.in_delay_slot ? it.current_pc - 32'd4 : it.current_pc;
        cause       |= code | (it.in_delay_slot ? CAUSE_BD : 32'd0);
        r.new_status = it.current_status | STATUS_EXL;
      end
      r.new_cause = cause;
      return r;
    endfunction

    function void note_request(item_t it);
      result_t r;
      r = predict_entry(it);
      op_seen[it.operation]++;
      if (r.taken) taken_seen++;
      if (r.fault_regs_valid) fault_seen++;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected, got %h", $time, act);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("taken", exp_r.taken, act.taken);
      compare_field("new_epc", exp_r.new_epc, act.new_epc);
      compare_field("new_cause", exp_r.new_cause, act.new_cause);
      compare_field("new_status", exp_r.new_status, act.new_status);
      compare_field("fault_regs_valid", exp_r.fault_regs_valid, act.fault_regs_valid);
      compare_field("bad_vaddr", exp_r.bad_vaddr, act.bad_vaddr);
      compare_field("context_word", exp_r.context_word, act.context_word);
      compare_field("entry_hi_word", exp_r.entry_hi_word, act.entry_hi_word);
      compare_field("next_pc", exp_r.next_pc, act.next_pc);
    endfunction
  endclass

  entry_scoreboard sb;

  mips_exception_entry_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // long receiver hold-off, counted in its own process
  initial begin
    snk_hold = 1'b0;
    forever begin
      @(start_hold);
      @(posedge clk_i);
      snk_hold = 1'b1;
      repeat (hold_len) @(posedge clk_i);
      snk_hold = 1'b0;
    end
  end

  // receiver ready, changed at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= !snk_hold && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    result_t act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act.taken            = m_axis_tdata[0];
      act.new_epc          = m_axis_tdata[32:1];
      act.new_cause        = m_axis_tdata[64:33];
      act.new_status       = m_axis_tdata[96:65];
      act.fault_regs_valid = m_axis_tdata[97];
      act.bad_vaddr        = m_axis_tdata[129:98];
      act.context_word     = m_axis_tdata[161:130];
      act.entry_hi_word    = m_axis_tdata[193:162];
      act.next_pc          = m_axis_tdata[225:194];
      sb.check_result(act);
    end
  end

  function automatic item_t make_item(op_e op, logic [31:0] addr, logic store,
                                      logic [31:0] pc, logic delay, logic [31:0] status,
                                      logic [31:0] cause, logic [31:0] count,
                                      logic [31:0] compare, logic pending);
    item_t it;
    it.operation         = op;
    it.address           = addr;
    it.is_store          = store;
    it.current_pc        = pc;
    it.in_delay_slot     = delay;
    it.current_status    = status;
    it.current_cause     = cause;
    it.count_value       = count;
    it.compare_value     = compare;
    it.interrupt_pending = pending;
    return it;
  endfunction

  // random request, biased towards interrupts that can actually be taken
  function automatic item_t random_item();
    item_t it;
    it = make_item(op_e'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                   $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                   $urandom, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) it.address = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    if ($urandom_range(0, 9) == 0) it.current_pc = $urandom_range(0, 7);
    if ($urandom_range(0, 1)) it.current_status[2:0] = STATUS_IE_ONLY;
    if ($urandom_range(0, 1)) it.compare_value = it.count_value;
    if ($urandom_range(0, 3) == 0) it.current_cause[15:8] = 8'd0;
    return it;
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.operation;
    s_axis_tdata  <= {5'd0, it.interrupt_pending, it.compare_value, it.count_value,
                      it.current_cause, it.current_status, it.in_delay_slot,
                      it.current_pc, it.is_store, it.address};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(it);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_request(random_item());
  endtask

  // watchdog
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // main sequence
  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_POLL;
    m_axis_tready = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_len      = 80;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: timer match, pending cleared, interrupt taken with either vector
    send_request(make_item(OP_POLL, 0, 0, 32'h1000, 0, 32'h0000_8001, 0, 5, 5, 1));
    send_request(make_item(OP_POLL, 0, 0, 32'h1000, 1, 32'h0040_8001, 0, 5, 5, 1));
    send_request(make_item(OP_POLL, 0, 0, 32'h1000, 0, 32'h0000_FF01, 32'hFFFF_FFFF, 7, 7, 0));
    send_request(make_item(OP_POLL, 0, 0, 32'h2000, 0, 32'h0000_0101, 32'h0000_0100, 1, 2, 1));
    send_request(make_item(OP_POLL, 0, 0, 32'h2000, 0, 32'h0040_0101, 32'h0000_0100, 1, 2, 1));
    // interrupt masked by mask bits, by EXL, by ERL and by IE clear
    send_request(make_item(OP_POLL, 0, 0, 32'h2000, 0, 32'h0000_0201, 32'h0000_0100, 1, 2, 1));
    send_request(make_item(OP_POLL, 0, 0, 32'h2000, 0, 32'h0000_FF03, 32'h0000_FF00, 1, 2, 1));
    send_request(make_item(OP_POLL, 0, 0, 32'h2000, 0, 32'h0000_FF05, 32'h0000_FF00, 1, 2, 1));
    send_request(make_item(OP_POLL, 0, 0, 32'h2000, 0, 32'h0000_FF00, 32'h0000_FF00, 1, 2, 1));
    send_request(make_item(OP_POLL, '1, 1, '1, 1, '1, '1, '1, '1, 1));
    send_request(make_item(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // tlb miss: load and store, address extremes, delay slot with pc wrap
    send_request(make_item(OP_TLB, 32'd0, 0, 32'd0, 1, 32'd0, 32'd0, 0, 1, 0));
    send_request(make_item(OP_TLB, 32'hFFFF_FFFF, 1, '1, 0, 32'h0040_0000, 0, 0, 1, 0));
    send_request(make_item(OP_TLB, 32'h0000_1FFF, 0, 32'h8000_0400, 0, '1, '1, 3, 3, 1));
    send_request(make_item(OP_TLB, 32'h0000_2000, 1, 32'h0000_0004, 1, 0, 0, 3, 3, 1));
    // breakpoint and trap with both vectors and both delay-slot settings
    send_request(make_item(OP_BREAK, 0, 0, 32'h8000_1234, 0, 32'd0, 32'd0, 0, 1, 0));
    send_request(make_item(OP_BREAK, '1, 1, 32'd2, 1, 32'h0040_0000, '1, 9, 9, 1));
    send_request(make_item(OP_TRAP, 0, 0, 32'h8000_1234, 1, 32'h0040_0000, 32'd0, 0, 1, 0));
    send_request(make_item(OP_TRAP, '1, 1, '1, 0, '1, '1, 9, 9, 1));
    send_request(make_item(OP_TRAP, 0, 0, 0, 1, 0, 0, 0, 0, 0));

    // random: no idling, idle sender, stalling receiver, then both
    send_random(260);
    src_idle_pct = 75;
    send_random(230);
    src_idle_pct  = 0;
    snk_stall_pct = 75;
    send_random(230);
    src_idle_pct  = 26;
    snk_stall_pct = 26;
    send_random(230);

    // back-pressure: receiver holds off while the sender keeps offering
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    -> start_hold;
    send_random(80);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d requests: poll %0d, tlb miss %0d, breakpoint %0d, trap %0d",
             sb.op_seen[OP_POLL] + sb.op_seen[OP_TLB] + sb.op_seen[OP_BREAK] +
             sb.op_seen[OP_TRAP], sb.op_seen[OP_POLL], sb.op_seen[OP_TLB],
             sb.op_seen[OP_BREAK], sb.op_seen[OP_TRAP]);
    $display("%0d exceptions entered, %0d with fault words, %0d mismatches",
             sb.taken_seen, sb.fault_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mee_pkg.sv
hdl/mee_logic.sv
hdl/mips_exception_entry_top.sv
sim/mips_exception_entry_top_test.sv
